@@ src/m64a_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m64a_pkg
// Shared constants, types and sequencer states of the 64-bit murmur hash.
// ----------------------------------------------------------------------------
package m64a_pkg;

    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT = 47;

    localparam int          LENGTH_WIDTH_DEF = 16;
    localparam logic [63:0] SEED_RESET       = 64'd11;

    // Field layout of the input word
    localparam int WORD_W     = 64;
    localparam int NBYTES_W   = 4;
    localparam int LEN_W      = 16;
    localparam int NBYTES_LSB = WORD_W;
    localparam int LEN_LSB    = WORD_W + NBYTES_W;
    localparam int S_DATA_W   = 88;

    localparam logic [NBYTES_W-1:0] BYTES_FULL = 4'd8;

    // Multiplier request and response
    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_KEY1,
        ST_KEY2,
        ST_HASH,
        ST_FIN,
        ST_OUT
    } seq_state_t;

endpackage
`default_nettype wire

@@ src/m64a_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m64a_mul
// Multiply by the mix constant, modulo 2^64, on one 32x32 multiplier over
// four steps; the product is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module m64a_mul (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire m64a_pkg::mul_req_t  req,
    output m64a_pkg::mul_rsp_t       rsp
);
    import m64a_pkg::*;

    localparam logic [31:0] M_LO = MIX_MUL[31:0];
    localparam logic [31:0] M_HI = MIX_MUL[63:32];

    logic [63:0] a_reg;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;

    // Partial products: lo*lo, lo*hi, hi*lo; only the low half of the cross
    // terms lands inside 64 bits.
    always_comb begin
        op_a      = (step_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
        op_b      = (step_reg == 2'd1) ? M_HI : M_LO;
        prod_next = {32'd0, op_a} * {32'd0, op_b};
        case (step_reg)
            2'd1:    acc_next = prod_reg;
            2'd2:    acc_next = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
            2'd3:    acc_next = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            done_reg <= !req.start && busy_reg && (step_reg == 2'd3);
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg <= req.operand;
        end
        if (busy_reg) begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule
`default_nettype wire

@@ src/murmur64a_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur64a_hash
// 64-bit murmur hash, variant 64A, over messages of 64-bit little-endian words.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per message chunk. s_tdata holds data_word, then
//   valid_bytes, then total_length; s_tuser marks the first word of a message
//   (whose total_length seeds the hash), s_tlast the last one. A word with
//   1 to 7 valid bytes is folded in as a tail, 0 valid bytes leaves the hash.
//   m_ channel: one finalized hash per message, after its last word.
//   cfg channel: seed register, always ready; write it only while idle.
// Schedule: every multiply by the mix constant runs on one shared 32x32
//   multiplier in four steps. A full word takes 3 multiplies, a tail word 1,
//   an empty word none. A first word adds the length multiply, a last word
//   the finalizer multiply and the output load. s_tready is high only while
//   the sequencer is idle.
// Reset: seed returns to 11, no message is open, no result is pending.
// Stall: a result waits in the output register; the next message is taken
//   meanwhile and only its own result waits for the register to free up.
// ----------------------------------------------------------------------------
module murmur64a_hash #(
    parameter int LENGTH_WIDTH = m64a_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // data_word [63:0], valid_bytes [67:64], total_length [83:68], zero pad
    input  wire logic [m64a_pkg::S_DATA_W-1:0]   s_tdata,
    // first_word [0]
    input  wire logic                            s_tuser,
    input  wire logic                            s_tlast,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // hash_value [63:0]
    output logic [63:0]                          m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [63:0]                     cfg_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready
);
    import m64a_pkg::*;

    // Length bits that enter the seed: the field is 16 bits wide
    localparam int LEN_BITS = (LENGTH_WIDTH < LEN_W) ? LENGTH_WIDTH : LEN_W;

    seq_state_t state_reg, state_next;

    logic                running_reg, running_next;
    logic                in_msg_reg, in_msg_next;
    logic                m_valid_reg, m_valid_next;
    logic [63:0]         seed_reg;
    logic [63:0]         h_reg, h_next;
    logic [63:0]         k_reg, k_next;
    logic [63:0]         word_reg, word_next;
    logic [NBYTES_W-1:0] nb_reg, nb_next;
    logic                last_reg, last_next;
    logic [63:0]         out_reg, out_next;

    logic                s_accept;
    logic [NBYTES_W-1:0] s_nbytes;
    logic [NBYTES_W-1:0] s_nb_clamped;
    logic [LEN_BITS-1:0] s_len;
    logic [63:0]         tail_mask;
    logic [63:0]         fin_mix;
    logic [63:0]         r;
    mul_req_t            mul_req;
    mul_rsp_t            mul_rsp;

    m64a_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_reg;

    assign s_nbytes     = s_tdata[NBYTES_LSB +: NBYTES_W];
    assign s_nb_clamped = (s_nbytes > BYTES_FULL) ? BYTES_FULL : s_nbytes;
    assign s_len        = s_tdata[LEN_LSB +: LEN_BITS];
    assign r            = mul_rsp.product;
    assign fin_mix      = r ^ (r >> MIX_SHIFT);

    // Keep the low valid bytes of a tail word
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            tail_mask[8*i +: 8] = (NBYTES_W'(i) < nb_reg) ? 8'hff : 8'h00;
        end
    end

    always_comb begin
        state_next    = state_reg;
        running_next  = running_reg;
        in_msg_next   = in_msg_reg;
        h_next        = h_reg;
        k_next        = k_reg;
        word_next     = word_reg;
        nb_next       = nb_reg;
        last_next     = last_reg;
        out_next      = out_reg;
        mul_req       = '0;

        // Drop the pending result once the receiver takes it
        m_valid_next  = m_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    word_next = s_tdata[WORD_W-1:0];
                    nb_next   = s_nb_clamped;
                    last_next = s_tlast;
                    if (s_tuser) begin
                        k_next     = 64'(s_len);
                        state_next = ST_LEN;
                    end else if (in_msg_reg) begin
                        if (s_nb_clamped == BYTES_FULL) begin
                            state_next = ST_KEY1;
                        end else if (s_nb_clamped != '0) begin
                            state_next = ST_HASH;
                        end else if (s_tlast) begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_LEN: begin
                mul_req.operand = k_reg;
                if (!running_reg) begin
                    mul_req.start = 1'b1;
                    running_next  = 1'b1;
                end else if (mul_rsp.done) begin
                    running_next = 1'b0;
                    h_next       = seed_reg ^ r;
                    in_msg_next  = 1'b1;
                    if (nb_reg == BYTES_FULL) begin
                        state_next = ST_KEY1;
                    end else if (nb_reg != '0) begin
                        state_next = ST_HASH;
                    end else if (last_reg) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_KEY1: begin
                mul_req.operand = word_reg;
                if (!running_reg) begin
                    mul_req.start = 1'b1;
                    running_next  = 1'b1;
                end else if (mul_rsp.done) begin
                    running_next = 1'b0;
                    k_next       = fin_mix;
                    state_next   = ST_KEY2;
                end
            end
            ST_KEY2: begin
                mul_req.operand = k_reg;
                if (!running_reg) begin
                    mul_req.start = 1'b1;
                    running_next  = 1'b1;
                end else if (mul_rsp.done) begin
                    running_next = 1'b0;
                    k_next       = r;
                    state_next   = ST_HASH;
                end
            end
            ST_HASH: begin
                mul_req.operand = (nb_reg == BYTES_FULL) ? (h_reg ^ k_reg)
                                                         : (h_reg ^ (word_reg & tail_mask));
                if (!running_reg) begin
                    mul_req.start = 1'b1;
                    running_next  = 1'b1;
                end else if (mul_rsp.done) begin
                    running_next = 1'b0;
                    h_next       = r;
                    if (last_reg) begin
                        state_next = ST_FIN;
                    end else begin
                        in_msg_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                mul_req.operand = h_reg ^ (h_reg >> MIX_SHIFT);
                if (!running_reg) begin
                    mul_req.start = 1'b1;
                    running_next  = 1'b1;
                end else if (mul_rsp.done) begin
                    running_next = 1'b0;
                    h_next       = fin_mix;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold the hash until the output register is free
                if (!m_valid_reg || m_tready) begin
                    out_next     = h_reg;
                    m_valid_next = 1'b1;
                    h_next       = '0;
                    in_msg_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                running_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            running_reg <= 1'b0;
            in_msg_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            seed_reg    <= SEED_RESET;
            h_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            running_reg <= running_next;
            in_msg_reg  <= in_msg_next;
            m_valid_reg <= m_valid_next;
            h_reg       <= h_next;
            if (cfg_valid && cfg_ready) begin
                seed_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        word_reg <= word_next;
        nb_reg   <= nb_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    // Never restart the multiplier while it is working
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_req.start |-> !running_reg)
        else $error("multiplier restarted while busy");

    // A product only comes back for an issued multiply
    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> running_reg)
        else $error("unexpected multiplier result");

    // A first word always begins with the length multiply
    a_first_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser) |=> (state_reg == ST_LEN))
        else $error("first word did not seed from length");

    // Leaving the output state always presents a result
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && state_next == ST_IDLE) |=> m_tvalid)
        else $error("finalized hash not presented");

    // No message stays open after its result has been loaded
    a_msg_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && state_next == ST_IDLE) |=> !in_msg_reg)
        else $error("message left open after result");

endmodule
`default_nettype wire
